>>> rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types for the preemptive priority scheduler
// Holds the load broadcast and the best-candidate record that moves along
// the row of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

	localparam int ID_W   = 8;
	localparam int TIME_W = 16;
	localparam int PRIO_W = 10;
	localparam int SLOT_W = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// Pending count saturates at two: zero, one, or more than one.
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_MANY = 2'd2;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] burst;
		logic [PRIO_W-1:0] prio;
	} pps_load_t;

	typedef struct packed {
		logic              have;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] arr;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] rem;
		logic [1:0]        pend;
	} pps_best_t;

endpackage : pps_pkg

`default_nettype wire

>>> rtl/pps_cell.sv
// ----------------------------------------------------------------------------
// pps_cell: one process slot of the scheduler row
// Stores one slot and merges it into the best candidate handed on from the
// previous cell, registering the result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_cell import pps_pkg::*; #(
	parameter int IDX   = 0,
	parameter int IDX_W = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pps_load_t         ld,
	input  wire logic              dec_en,
	input  wire logic [IDX_W-1:0]  dec_slot,
	input  wire logic [TIME_W-1:0] now_time,
	input  wire pps_best_t         best_i,
	input  wire logic [IDX_W-1:0]  slot_i,
	output pps_best_t              best_o,
	output logic [IDX_W-1:0]       slot_o
);

	logic              valid_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] arr_q;
	logic [TIME_W-1:0] burst_q;
	logic [TIME_W-1:0] rem_q;
	logic [PRIO_W-1:0] prio_q;

	logic      ld_hit;
	logic      dec_hit;
	logic      pending;
	logic      eligible;
	logic      better;
	pps_best_t best_d;
	logic [IDX_W-1:0] slot_d;

	assign ld_hit  = ld.en && (32'(ld.slot) == IDX);
	assign dec_hit = dec_en && (dec_slot == IDX_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld_hit) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_hit) begin
			id_q    <= ld.id;
			arr_q   <= ld.arr;
			burst_q <= ld.burst;
			rem_q   <= ld.burst;
			prio_q  <= ld.prio;
		end else if (dec_hit) begin
			rem_q <= rem_q - TIME_W'(1);
		end
	end

	// Strict comparisons keep an earlier slot on a full tie.
	assign pending  = valid_q && (rem_q != '0);
	assign eligible = pending && (arr_q <= now_time);
	assign better   = !best_i.have || (prio_q < best_i.prio) ||
	                  ((prio_q == best_i.prio) && (arr_q < best_i.arr));

	always_comb begin
		best_d = best_i;
		slot_d = slot_i;
		if (eligible && better) begin
			best_d.have  = 1'b1;
			best_d.prio  = prio_q;
			best_d.arr   = arr_q;
			best_d.id    = id_q;
			best_d.burst = burst_q;
			best_d.rem   = rem_q;
			slot_d       = IDX_W'(IDX);
		end
		if (pending) begin
			best_d.pend = (best_i.pend == PEND_NONE) ? PEND_ONE : PEND_MANY;
		end
	end

	always_ff @(posedge clk) begin
		best_o <= best_d;
		slot_o <= slot_d;
	end

endmodule : pps_cell

`default_nettype wire

>>> rtl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: preemptive priority process scheduler
// A row of slot cells picks the ready process with the lowest priority value
// on every tick item and charges it one unit of service.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Carries
//  --------+-----------+------------------------------------------------------
//  s_*     | in        | load item (tuser 0) or tick item (tuser 1)
//  m_*     | out       | one result item per tick item, none per load item
//
// A load item is taken while the block is idle and writes its slot directly.
// A tick item lets the candidate record ripple through the row of MAX_PROCS
// registered cells, one cell per cycle, and then the block updates the time,
// charges the chosen slot and fills the output register.
// The next item is taken in the cycle after that, so no new item is taken
// while a tick is in progress.
// Reset clears the slot valid flags, the time count, the result register and
// the control state; the slot contents are undefined until loaded.
// If the output register is still full when a tick completes, the block holds
// the tick until the result has been taken and accepts no new item meanwhile.
//
`default_nettype none

module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int MAX_PROCS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// slot[3:0], proc_id[11:4], arrival_time[27:12], burst_length[43:28],
	// priority_level[53:44], zero fill[55:54]
	input  wire logic [55:0] s_tdata,
	// mode[0]
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// run_id[7:0], tick_end_time[23:8], finished[24], turnaround[40:25],
	// waiting[56:41], all_done[57], zero fill[63:58]
	output logic [63:0]      m_tdata,
	// idle[0]
	output logic [0:0]       m_tuser
);

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] now_q;

	logic      in_fire;
	logic      out_free;
	logic      done_fire;
	pps_load_t ld;

	// The candidate chain: entry 0 feeds the first cell, the last entry is
	// the winner after a full ripple.
	pps_best_t        best_w [MAX_PROCS+1];
	logic [IDX_W-1:0] slot_w [MAX_PROCS+1];
	pps_best_t        best;

	logic [TIME_W-1:0] end_time;
	logic [TIME_W-1:0] tat;
	logic [TIME_W-1:0] wt;
	logic              fin;
	logic              all_done;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign done_fire = (state_q == ST_DONE) && out_free;

	// Load items are broadcast straight to the row; the addressed cell
	// captures them at the accepting edge.
	assign ld.en    = in_fire && (s_tuser[0] == MODE_LOAD);
	assign ld.slot  = s_tdata[3:0];
	assign ld.id    = s_tdata[11:4];
	assign ld.arr   = s_tdata[27:12];
	assign ld.burst = s_tdata[43:28];
	assign ld.prio  = s_tdata[53:44];

	assign best_w[0] = '{have: 1'b0, prio: '0, arr: '0, id: '0, burst: '0,
	                     rem: '0, pend: PEND_NONE};
	assign slot_w[0] = '0;

	for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
		pps_cell #(
			.IDX   (k),
			.IDX_W (IDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ld       (ld),
			.dec_en   (done_fire && best.have),
			.dec_slot (slot_w[MAX_PROCS]),
			.now_time (now_q),
			.best_i   (best_w[k]),
			.slot_i   (slot_w[k]),
			.best_o   (best_w[k+1]),
			.slot_o   (slot_w[k+1])
		);
	end

	assign best = best_w[MAX_PROCS];

	// The chosen process is always arrived, so the end time is never below its
	// arrival and the turnaround fits without wrapping.
	assign end_time = (now_q == TIME_MAX) ? now_q : now_q + TIME_W'(1);
	assign fin      = best.have && (best.rem == TIME_W'(1));
	assign tat      = end_time - best.arr;
	assign wt       = (tat >= best.burst) ? tat - best.burst : '0;

	// The chosen process is itself pending, so it finishing leaves the table
	// done exactly when it was the only pending slot.
	assign all_done = best.have ? (fin && (best.pend == PEND_ONE))
	                            : (best.pend == PEND_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			now_q    <= '0;
			m_tvalid <= 1'b0;
			m_tuser  <= '0;
			m_tdata  <= '0;
		end else begin
			// A completing tick refills the result register at the same edge
			// at which the previous result leaves it.
			if (done_fire) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (s_tuser[0] == MODE_TICK)) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MAX_PROCS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						now_q          <= end_time;
						m_tuser[0]     <= !best.have;
						m_tdata[7:0]   <= best.have ? best.id : '0;
						m_tdata[23:8]  <= end_time;
						m_tdata[24]    <= fin;
						m_tdata[40:25] <= fin ? tat : '0;
						m_tdata[56:41] <= fin ? wt : '0;
						m_tdata[57]    <= all_done;
						m_tdata[63:58] <= '0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result may only be loaded once the scan has run its full length.
	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> ($past(state_q) == ST_DONE) ||
		                         ($past(cnt_q) == CNT_W'(MAX_PROCS - 1)))
		else $error("tick completed before the row had settled");

	// Time only moves forwards, by at most one per tick.
	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (now_q == $past(now_q)) || (now_q == $past(now_q) + TIME_W'(1)))
		else $error("time count stepped other than by one");

	// Time changes only on a completed tick.
	a_time_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!done_fire |=> $stable(now_q))
		else $error("time count moved without a tick");

	// A finished flag never accompanies an idle tick.
	a_idle_not_finished: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[24] && (m_tdata[7:0] == '0))
		else $error("idle tick reported a running process");
`endif

endmodule : preemptive_priority_scheduler

`default_nettype wire
